// ----- rtl/core/rmm_pkg.sv -----
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared constants, types and elaboration-time helpers for the residue
// number system modular multiplier.
// ----------------------------------------------------------------------------
package rmm_pkg;

    // Operand and result widths
    localparam int OPND_W   = 31;
    localparam int OUT_W    = 32;

    // Channel set
    localparam int CHAN_MAX = 9;
    localparam int MODULI    [CHAN_MAX] = '{3, 5, 7, 11, 13, 17, 19, 23, 29};
    localparam int RADIX_LOG [CHAN_MAX] = '{2, 3, 3, 4, 4, 5, 5, 5, 5};

    // Per-channel datapath widths
    localparam int RES_W    = 5;    // residue, below 29
    localparam int SUM_W    = 15;   // weighted byte sum, below 2^15
    localparam int QSHIFT   = 20;   // reciprocal scale for the byte-sum reduction
    localparam int RECIP_W  = 19;   // reciprocal constant width
    localparam int QUO_W    = 14;   // quotient of the byte-sum reduction
    localparam int PROD_W   = 10;   // product of two residues
    localparam int REDC_W   = 11;   // t + m*n inside Montgomery reduction
    localparam int CH_STAGES = 9;   // register stages inside one channel

    // Reconstruction tree
    localparam int TREE_LVLS = 4;
    localparam int LEAVES    = 1 << TREE_LVLS;
    localparam int NSTAGE    = CH_STAGES + TREE_LVLS;

    typedef logic [OUT_W-1:0] word_t;

    // Bring a small non-negative value below n by repeated subtraction
    function automatic int red_small(input int x, input int n);
        int v;
        v = x;
        for (int k = 0; k < 64; k++) begin
            if (v >= n) v = v - n;
        end
        return v;
    endfunction

    // x*y mod n for x, y below n (n at most 32), by repeated addition
    function automatic int mul_mod(input int x, input int y, input int n);
        int acc;
        acc = 0;
        for (int k = 0; k < 32; k++) begin
            if (k < y) begin
                acc = acc + x;
                if (acc >= n) acc = acc - n;
            end
        end
        return acc;
    endfunction

    // 2^e mod n, by repeated doubling
    function automatic int pow2_mod(input int e, input int n);
        int v;
        v = red_small(1, n);
        for (int k = 0; k < 40; k++) begin
            if (k < e) begin
                v = v * 2;
                if (v >= n) v = v - n;
            end
        end
        return v;
    endfunction

    // Smallest k below n with x*k mod n equal to one; zero when none exists
    function automatic int inv_mod(input int x, input int n);
        int  r;
        bit  found;
        r     = 0;
        found = 1'b0;
        for (int k = 0; k < 32; k++) begin
            if (k < n && !found && mul_mod(x, k, n) == red_small(1, n)) begin
                r     = k;
                found = 1'b1;
            end
        end
        return r;
    endfunction

    // -n^-1 mod 2^lr
    function automatic int neg_inv_pow2(input int n, input int lr);
        int  r;
        int  msk;
        bit  found;
        msk   = (1 << lr) - 1;
        r     = 0;
        found = 1'b0;
        for (int k = 0; k < 32; k++) begin
            if (k <= msk && !found && ((n * k) & msk) == 1) begin
                r     = k;
                found = 1'b1;
            end
        end
        return ((1 << lr) - r) & msk;
    endfunction

    // Product of the active moduli other than channel i, reduced mod n
    function automatic int mi_mod(input int i, input int nc, input int n);
        int p;
        p = red_small(1, n);
        for (int j = 0; j < CHAN_MAX; j++) begin
            if (j < nc && j != i) p = mul_mod(p, red_small(MODULI[j], n), n);
        end
        return p;
    endfunction

    // Product of the active moduli other than channel i
    function automatic longint mi_val(input int i, input int nc);
        longint p;
        p = 1;
        for (int j = 0; j < CHAN_MAX; j++) begin
            if (j < nc && j != i) p = p * MODULI[j];
        end
        return p;
    endfunction

    // Product of all active moduli
    function automatic longint m_val(input int nc);
        longint p;
        p = 1;
        for (int j = 0; j < CHAN_MAX; j++) begin
            if (j < nc) p = p * MODULI[j];
        end
        return p;
    endfunction

    // Modular addition of two values below m
    function automatic word_t mod_add(input word_t x, input word_t y,
                                      input logic [OUT_W:0] m);
        logic [OUT_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= m) s = s - m;
        return s[OUT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/rmm_channel.sv -----
// ----------------------------------------------------------------------------
// rmm_channel
// One residue channel: reduces both operands into Montgomery form, runs
// the residue product through two Montgomery reductions and scales the
// result into its share of the reconstructed product.
// ----------------------------------------------------------------------------
module rmm_channel #(
    parameter int IDX          = 0,
    parameter int NUM_CHANNELS = rmm_pkg::CHAN_MAX
) (
    input  logic                                clk,
    input  logic [rmm_pkg::CH_STAGES-1:0]       ld,
    input  logic [rmm_pkg::OPND_W-1:0]          operand_a,
    input  logic [rmm_pkg::OPND_W-1:0]          operand_b,
    output rmm_pkg::word_t                      term
);

    localparam int N   = rmm_pkg::MODULI[IDX];
    localparam int LR  = rmm_pkg::RADIX_LOG[IDX];
    localparam int CI  = rmm_pkg::inv_mod(rmm_pkg::mi_mod(IDX, NUM_CHANNELS, N), N);
    localparam int NP  = rmm_pkg::neg_inv_pow2(N, LR);

    localparam int SW  = rmm_pkg::SUM_W;
    localparam int RW  = rmm_pkg::RES_W;
    localparam int PW  = rmm_pkg::PROD_W;
    localparam int DW  = rmm_pkg::REDC_W;
    localparam int QW  = rmm_pkg::QUO_W;
    localparam int KW  = rmm_pkg::RECIP_W;
    localparam int XW  = SW + KW;

    // Byte weights: 2^(8k)*R mod n for a, with the CRT inverse folded in for b
    localparam logic [SW-1:0] WA0 = SW'(rmm_pkg::pow2_mod(LR, N));
    localparam logic [SW-1:0] WA1 = SW'(rmm_pkg::pow2_mod(8 + LR, N));
    localparam logic [SW-1:0] WA2 = SW'(rmm_pkg::pow2_mod(16 + LR, N));
    localparam logic [SW-1:0] WA3 = SW'(rmm_pkg::pow2_mod(24 + LR, N));
    localparam logic [SW-1:0] WB0 = SW'(rmm_pkg::mul_mod(int'(WA0), CI, N));
    localparam logic [SW-1:0] WB1 = SW'(rmm_pkg::mul_mod(int'(WA1), CI, N));
    localparam logic [SW-1:0] WB2 = SW'(rmm_pkg::mul_mod(int'(WA2), CI, N));
    localparam logic [SW-1:0] WB3 = SW'(rmm_pkg::mul_mod(int'(WA3), CI, N));

    localparam int             RECIP = (1 << rmm_pkg::QSHIFT) / N;
    localparam logic [XW-1:0]  K_X   = XW'(RECIP);
    localparam logic [SW-1:0]  N_S   = SW'(N);
    localparam logic [RW:0]    N_R   = (RW + 1)'(N);
    localparam logic [DW-1:0]  N_D   = DW'(N);
    localparam logic [PW+RW-1:0] NP_X = (PW + RW)'(NP);
    localparam logic [PW+RW-1:0] RMSK = (PW + RW)'((1 << LR) - 1);
    localparam rmm_pkg::word_t MI    = rmm_pkg::word_t'(rmm_pkg::mi_val(IDX, NUM_CHANNELS));

    logic [SW-1:0]  sa_reg, sb_reg;
    logic [QW-1:0]  qa_reg, qb_reg;
    logic [SW-1:0]  sa2_reg, sb2_reg;
    logic [RW-1:0]  am_reg, bm_reg;
    logic [PW-1:0]  t_reg, t5_reg;
    logic [RW-1:0]  m1_reg, f_reg, f7_reg, m2_reg, w_reg;
    rmm_pkg::word_t term_reg;

    logic [XW-1:0]  pa_x, pb_x;
    logic [SW-1:0]  ra_s, rb_s;
    logic [RW:0]    ra, rb;
    logic [PW+RW-1:0] tn1, tn2;
    logic [DW-1:0]  u1_d, u2_d;
    logic [RW:0]    u1, u2;

    // Reciprocal quotient and remainder for the byte sums
    always_comb
    begin
        pa_x = XW'(sa_reg) * K_X;
        pb_x = XW'(sb_reg) * K_X;
        ra_s = sa2_reg - SW'(SW'(qa_reg) * N_S);
        rb_s = sb2_reg - SW'(SW'(qb_reg) * N_S);
        ra   = ra_s[RW:0];
        rb   = rb_s[RW:0];
    end

    // Montgomery reduction steps
    always_comb
    begin
        tn1  = ((PW + RW)'(t_reg) * NP_X) & RMSK;
        u1_d = (DW'(t5_reg) + DW'(DW'(m1_reg) * N_D)) >> LR;
        u1   = u1_d[RW:0];
        tn2  = ((PW + RW)'(f_reg) * NP_X) & RMSK;
        u2_d = (DW'(f7_reg) + DW'(DW'(m2_reg) * N_D)) >> LR;
        u2   = u2_d[RW:0];
    end

    // Stage 1: weighted byte sums
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            sa_reg <= SW'(operand_a[7:0]) * WA0 + SW'(operand_a[15:8]) * WA1
                    + SW'(operand_a[23:16]) * WA2 + SW'(operand_a[30:24]) * WA3;
            sb_reg <= SW'(operand_b[7:0]) * WB0 + SW'(operand_b[15:8]) * WB1
                    + SW'(operand_b[23:16]) * WB2 + SW'(operand_b[30:24]) * WB3;
        end
    end

    // Stage 2: approximate quotient
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            qa_reg  <= pa_x[XW-1 -: QW];
            qb_reg  <= pb_x[XW-1 -: QW];
            sa2_reg <= sa_reg;
            sb2_reg <= sb_reg;
        end
    end

    // Stage 3: remainder with one correction gives the Montgomery forms
    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            am_reg <= RW'((ra >= N_R) ? ra - N_R : ra);
            bm_reg <= RW'((rb >= N_R) ? rb - N_R : rb);
        end
    end

    // Stage 4: residue product
    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            t_reg <= PW'(am_reg) * PW'(bm_reg);
        end
    end

    // Stage 5: first reduction factor
    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            m1_reg <= RW'(tn1);
            t5_reg <= t_reg;
        end
    end

    // Stage 6: first reduction result
    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            f_reg <= RW'((u1 >= N_R) ? u1 - N_R : u1);
        end
    end

    // Stage 7: second reduction factor
    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            m2_reg <= RW'(tn2);
            f7_reg <= f_reg;
        end
    end

    // Stage 8: second reduction leaves the CRT-weighted residue
    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            w_reg <= RW'((u2 >= N_R) ? u2 - N_R : u2);
        end
    end

    // Stage 9: scale by the product of the other moduli
    always_ff @(posedge clk)
    begin
        if (ld[8])
        begin
            term_reg <= rmm_pkg::word_t'(MI * rmm_pkg::word_t'(w_reg));
        end
    end

    assign term = term_reg;

endmodule

// ----- rtl/core/rns_modular_multiplier.sv -----
// ----------------------------------------------------------------------------
// rns_modular_multiplier
// Product of two 31-bit operands modulo the product of the active channel
// moduli, computed in residue channels with Montgomery reduction and
// rebuilt by Chinese remainder reconstruction.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  operand_a[30:0], operand_b[30:0]
//   output   out        out_valid / out_stall product_mod[31:0]
//
// One operand pair enters per cycle while in_stall is low; each result
// passes through nine channel stages and four levels of the modular
// adder tree, each stage one register.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stall on the output freezes the last stage; earlier stages keep moving
// until they catch up with it, so bubbles are squeezed out before the input
// stalls.
// ----------------------------------------------------------------------------
module rns_modular_multiplier #(
    parameter int NUM_CHANNELS = rmm_pkg::CHAN_MAX
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rmm_pkg::OPND_W-1:0]  operand_a,
    input  logic [rmm_pkg::OPND_W-1:0]  operand_b,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rmm_pkg::OUT_W-1:0]   product_mod
);

    localparam int NS  = rmm_pkg::NSTAGE;
    localparam int CS  = rmm_pkg::CH_STAGES;
    localparam logic [rmm_pkg::OUT_W:0] MOD_M =
        (rmm_pkg::OUT_W + 1)'(rmm_pkg::m_val(NUM_CHANNELS));

    logic [NS-1:0]   vld_reg;
    logic [NS-1:0]   ld;
    rmm_pkg::word_t  leaf     [rmm_pkg::LEAVES];
    rmm_pkg::word_t  lvl1_reg [8];
    rmm_pkg::word_t  lvl2_reg [4];
    rmm_pkg::word_t  lvl3_reg [2];
    rmm_pkg::word_t  out_reg;

    // Stage load enables: a stage loads when empty or when its successor loads
    always_comb
    begin
        ld[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    assign in_stall = !ld[0];

    // Advance valid bits alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (ld[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Residue channels; unused leaves contribute zero
    for (genvar c = 0; c < rmm_pkg::LEAVES; c++)
    begin : g_chan
        if (c < NUM_CHANNELS)
        begin : g_on
            rmm_channel #(
                .IDX          (c),
                .NUM_CHANNELS (NUM_CHANNELS)
            ) u_chan (
                .clk       (clk),
                .ld        (ld[CS-1:0]),
                .operand_a (operand_a),
                .operand_b (operand_b),
                .term      (leaf[c])
            );
        end
        else
        begin : g_off
            assign leaf[c] = '0;
        end
    end

    // Modular adder tree, one level per stage
    always_ff @(posedge clk)
    begin
        if (ld[CS])
        begin
            for (int k = 0; k < 8; k++)
            begin
                lvl1_reg[k] <= rmm_pkg::mod_add(leaf[2*k], leaf[2*k+1], MOD_M);
            end
        end
        if (ld[CS+1])
        begin
            for (int k = 0; k < 4; k++)
            begin
                lvl2_reg[k] <= rmm_pkg::mod_add(lvl1_reg[2*k], lvl1_reg[2*k+1], MOD_M);
            end
        end
        if (ld[CS+2])
        begin
            for (int k = 0; k < 2; k++)
            begin
                lvl3_reg[k] <= rmm_pkg::mod_add(lvl2_reg[2*k], lvl2_reg[2*k+1], MOD_M);
            end
        end
        if (ld[CS+3])
        begin
            out_reg <= rmm_pkg::mod_add(lvl3_reg[0], lvl3_reg[1], MOD_M);
        end
    end

    assign out_valid   = vld_reg[NS-1];
    assign product_mod = out_reg;

    // A delivered product is always reduced below the modulus
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, product_mod} < MOD_M))
        else $error("product_mod not reduced below the modulus");

    // Input stalls only when every stage holds a word and the output is stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&vld_reg) && out_stall))
        else $error("input stalled with a bubble in the pipeline");

    // A held result with no stall below it never blocks the input
    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the residue-channel modular multiplier. A driver
// presents operand pairs from a queue with random idle bursts, the output
// side stalls in random bursts, and a monitor compares every product word
// with a channel-by-channel Montgomery and CRT prediction of a*b mod M.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CHANNELS        = 9;
    localparam int ACTIVE_CHANNELS = (CHANNELS < rmm_pkg::CHAN_MAX) ? CHANNELS
                                                                    : rmm_pkg::CHAN_MAX;
    localparam int RANDOM_PAIRS    = 1300;
    localparam int CALM_TAIL       = 150;   // last pairs run without any idling
    localparam int DRAIN_CYCLES    = 40;    // pipeline is 13 deep
    localparam logic [rmm_pkg::OPND_W-1:0] OPND_MAX = {rmm_pkg::OPND_W{1'b1}};

    localparam longint unsigned RESIDUE_MODULI [rmm_pkg::CHAN_MAX] =
        '{3, 5, 7, 11, 13, 17, 19, 23, 29};
    localparam longint unsigned MONT_RADIX [rmm_pkg::CHAN_MAX] =
        '{4, 8, 8, 16, 16, 32, 32, 32, 32};

    typedef struct packed {
        logic [rmm_pkg::OPND_W-1:0] a;
        logic [rmm_pkg::OPND_W-1:0] b;
    } operand_pair_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [rmm_pkg::OPND_W-1:0] operand_a;
    logic [rmm_pkg::OPND_W-1:0] operand_b;
    logic                       out_valid;
    logic                       out_stall;
    rmm_pkg::word_t             product_mod;

    operand_pair_t  pending_pairs[$];
    rmm_pkg::word_t expected_products[$];
    int             error_count;
    logic           in_fire;
    int             in_idle_pct;
    int             out_idle_pct;
    int unsigned    window_cycle;

    rns_modular_multiplier #(
        .NUM_CHANNELS (CHANNELS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .product_mod (product_mod)
    );

    // Smallest k below m with x*k mod m equal to one, zero when there is none
    function automatic longint unsigned inverse_mod(input longint unsigned x,
                                                    input longint unsigned m);
        longint unsigned xr;
        longint unsigned inv;
        bit              found;
        xr    = x % m;
        inv   = 0;
        found = 1'b0;
        for (longint unsigned k = 0; k < m; k++) begin
            if (!found && (xr * k) % m == 1 % m) begin
                inv   = k;
                found = 1'b1;
            end
        end
        return inv;
    endfunction

    // Montgomery reduction: t * r^-1 mod n, with np = -n^-1 mod r
    function automatic longint unsigned mont_reduce(input longint unsigned t,
                                                    input longint unsigned n,
                                                    input longint unsigned r,
                                                    input longint unsigned np);
        longint unsigned q;
        q = (t * np) % r;
        return ((t + q * n) / r) % n;
    endfunction

    // Residue channels with double Montgomery reduction, then CRT rebuild
    function automatic rmm_pkg::word_t predict_product_mod(
        input logic [rmm_pkg::OPND_W-1:0] a,
        input logic [rmm_pkg::OPND_W-1:0] b);
        longint unsigned chan_res [rmm_pkg::CHAN_MAX];
        longint unsigned big_m;
        longint unsigned acc;
        longint unsigned n;
        longint unsigned r;
        longint unsigned np;
        longint unsigned am;
        longint unsigned bm;
        longint unsigned first;
        longint unsigned mi;
        longint unsigned ci;
        big_m = 1;
        acc   = 0;
        for (int i = 0; i < ACTIVE_CHANNELS; i++) begin
            n           = RESIDUE_MODULI[i];
            r           = MONT_RADIX[i];
            np          = (r - inverse_mod(n, r)) % r;
            am          = ((64'(a) % n) * r) % n;
            bm          = ((64'(b) % n) * r) % n;
            first       = mont_reduce(am * bm, n, r, np);
            chan_res[i] = mont_reduce(first, n, r, np);
            big_m       = big_m * n;
        end
        for (int i = 0; i < ACTIVE_CHANNELS; i++) begin
            n   = RESIDUE_MODULI[i];
            mi  = big_m / n;
            ci  = inverse_mod(mi, n);
            acc = (acc + (mi * ((ci * chan_res[i]) % n)) % big_m) % big_m;
        end
        return rmm_pkg::word_t'(acc);
    endfunction

    // Operand with a random shape: full range, small, modulus multiple,
    // near the top, sparse or dense bits
    function automatic logic [rmm_pkg::OPND_W-1:0] pick_operand();
        logic [rmm_pkg::OPND_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = (rmm_pkg::OPND_W)'($urandom_range(0, 1000));
            1: v = (rmm_pkg::OPND_W)'(RESIDUE_MODULI[$urandom_range(0, rmm_pkg::CHAN_MAX - 1)] *
                                      $urandom_range(0, 70000000));
            2: v = (rmm_pkg::OPND_W)'(OPND_MAX - $urandom_range(0, 255));
            3: v = (rmm_pkg::OPND_W)'($urandom() & $urandom());
            4: v = (rmm_pkg::OPND_W)'($urandom() | $urandom());
            default: v = (rmm_pkg::OPND_W)'($urandom());
        endcase
        return v;
    endfunction

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #400_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reset, stimulus queue fill and end of run
    initial
    begin
        rst_n       = 1'b0;
        error_count = 0;

        // directed: extremes, zero products, exact multiples of M
        pending_pairs.push_back('{a: '0,              b: '0});
        pending_pairs.push_back('{a: '0,              b: OPND_MAX});
        pending_pairs.push_back('{a: OPND_MAX,        b: '0});
        pending_pairs.push_back('{a: 31'd1,           b: 31'd1});
        pending_pairs.push_back('{a: 31'd1,           b: OPND_MAX});
        pending_pairs.push_back('{a: OPND_MAX,        b: 31'd1});
        pending_pairs.push_back('{a: OPND_MAX,        b: OPND_MAX});
        pending_pairs.push_back('{a: OPND_MAX - 1,    b: OPND_MAX});
        pending_pairs.push_back('{a: 31'h4000_0000,   b: 31'h4000_0000});
        pending_pairs.push_back('{a: 31'h5555_5555,   b: 31'h2AAA_AAAA});
        pending_pairs.push_back('{a: 31'h2AAA_AAAA,   b: 31'h5555_5555});
        pending_pairs.push_back('{a: 31'd15015,       b: 31'd215441});
        pending_pairs.push_back('{a: 31'd1078282205,  b: 31'd3});
        pending_pairs.push_back('{a: 31'd1078282205,  b: 31'd4});
        pending_pairs.push_back('{a: 31'd111546435,   b: 31'd58});
        pending_pairs.push_back('{a: 31'd111546435,   b: 31'd30});
        pending_pairs.push_back('{a: 31'd28,          b: 31'd28});
        pending_pairs.push_back('{a: 31'd29,          b: 31'd30});
        pending_pairs.push_back('{a: 31'd2,           b: 31'd3});
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            pending_pairs.push_back('{a: pick_operand(), b: pick_operand()});
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for all words to go in and come back out
        @(negedge clk);
        while (pending_pairs.size() > 0 || in_valid)
        begin
            @(negedge clk);
        end
        while (expected_products.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Pick new idling odds at the start of each window_cycle window; zero gives quiet stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_cycle <= 0;
            in_idle_pct  <= 0;
            out_idle_pct <= 0;
        end
        else
        begin
            window_cycle <= window_cycle + 1;
            if (window_cycle % 64 == 0)
            begin
                in_idle_pct  <= 10 * $urandom_range(0, 3);
                out_idle_pct <= 10 * $urandom_range(0, 3);
            end
        end
    end

    // Input driver: advance on acceptance, insert idle bursts between words
    always @(negedge clk or negedge rst_n)
    begin
        static int in_gap = 0;
        operand_pair_t pair;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operand_a <= '0;
            operand_b <= '0;
        end
        else if (!in_valid || in_fire)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   = in_gap - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                pair      = pending_pairs.pop_front();
                operand_a <= pair.a;
                operand_b <= pair.b;
                in_valid  <= 1'b1;
                if (pending_pairs.size() >= CALM_TAIL &&
                    $urandom_range(1, 100) <= in_idle_pct)
                begin
                    in_gap = $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall driver: stall in random bursts
    always @(negedge clk or negedge rst_n)
    begin
        static int stall_left = 0;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left = stall_left - 1;
        end
        else if (pending_pairs.size() >= CALM_TAIL &&
                 $urandom_range(1, 100) <= out_idle_pct)
        begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 5);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Input monitor: predict the product of every accepted word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_products.push_back(predict_product_mod(operand_a, operand_b));
            end
        end
    end

    // Output monitor: compare every accepted word with the oldest prediction
    always @(posedge clk)
    begin
        rmm_pkg::word_t expected_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_products.size() == 0)
            begin
                $error("product_mod: unexpected word %0d, none pending", product_mod);
                error_count <= error_count + 1;
            end
            else
            begin
                expected_word = expected_products.pop_front();
                if (product_mod !== expected_word)
                begin
                    $error("product_mod: expected %0d, actual %0d",
                           expected_word, product_mod);
                    error_count <= error_count + 1;
                end
            end
        end
    end

endmodule
